[sv/rgb_median_filter_3x3_macros.svh]
// Assertion macros used by the filter RTL.
`ifndef RGB_MEDIAN_FILTER_3X3_MACROS_SVH
`define RGB_MEDIAN_FILTER_3X3_MACROS_SVH

`ifndef SYNTHESIS
// Condition implies consequence in the same cycle.
`define RMF_ASSERT_NOW(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("rmf assertion failed");
// Condition implies consequence in the next cycle.
`define RMF_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("rmf assertion failed");
`else
`define RMF_ASSERT_NOW(label, clk, rst_n, cond, cons)
`define RMF_ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif

`endif

[sv/rmf_pkg.sv]
`default_nettype none
package rmf_pkg;
	localparam int DEF_MAX_WIDTH = 1024;
	localparam int DEF_CHANNEL_BITS = 8;
	localparam int WIN = 9;
	localparam int WIDTH_BITS = 11;
	localparam int HEIGHT_BITS = 12;
	localparam int CFG_DATA_BITS = 12;
	localparam int CFG_IDX_BITS = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 1'd1;

	localparam logic [WIDTH_BITS-1:0] RST_WIDTH = 11'd1024;
	localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT = 12'd768;

	typedef struct packed {
		logic load;
		logic [WIN-1:0] mask;
	} lane_ctl_t;
endpackage
`default_nettype wire

[sv/rmf_pix_in_if.sv]
`default_nettype none
interface rmf_pix_in_if #(parameter int CHANNEL_BITS = rmf_pkg::DEF_CHANNEL_BITS);
	logic valid;
	logic ready;
	logic [CHANNEL_BITS-1:0] in_red;
	logic [CHANNEL_BITS-1:0] in_green;
	logic [CHANNEL_BITS-1:0] in_blue;
	logic drain;

	modport source (output valid, in_red, in_green, in_blue, drain, input ready);
	modport sink (input valid, in_red, in_green, in_blue, drain, output ready);
endinterface
`default_nettype wire

[sv/rmf_pix_out_if.sv]
`default_nettype none
interface rmf_pix_out_if #(parameter int CHANNEL_BITS = rmf_pkg::DEF_CHANNEL_BITS);
	logic valid;
	logic ready;
	logic [CHANNEL_BITS-1:0] out_red;
	logic [CHANNEL_BITS-1:0] out_green;
	logic [CHANNEL_BITS-1:0] out_blue;
	logic last_pixel;

	modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
	modport sink (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface
`default_nettype wire

[sv/rmf_ram.sv]
`default_nettype none
module rmf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = rmf_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/rmf_lane.sv]
`default_nettype none
module rmf_lane #(
	parameter int CHANNEL_BITS = rmf_pkg::DEF_CHANNEL_BITS
) (
	input  wire logic                                         clk,
	input  wire rmf_pkg::lane_ctl_t                           ctl,
	input  wire logic [rmf_pkg::WIN-1:0][CHANNEL_BITS-1:0]    vals,
	output logic      [CHANNEL_BITS-1:0]                      median
);
	localparam int N = rmf_pkg::WIN;

	logic [N-1:0][CHANNEL_BITS-1:0] val_s2;
	logic [N-1:0]                   mask_s2;
	logic [N-1:0][N-1:0]            below;
	logic [N-1:0][N-1:0]            below_s2;
	logic [3:0]                     target;

	// below[i][j]: element j sorts ahead of element i (ties broken by position)
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				below[i][j] = (i != j) &&
					((vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			val_s2   <= vals;
			mask_s2  <= ctl.mask;
			below_s2 <= below;
		end
	end

	// pick the in-image element whose rank among in-image elements is n/2
	always_comb begin
		target = 4'($countones(mask_s2)) >> 1;
		median = '0;
		for (int i = 0; i < N; i++) begin
			if (mask_s2[i] && (4'($countones(mask_s2 & below_s2[i])) == target)) begin
				median = median | val_s2[i];
			end
		end
	end
endmodule
`default_nettype wire

[sv/rgb_median_filter_3x3.sv]
// Channel    Dir  Word                                   Handshake
// pix_in     in   in_red, in_green, in_blue, drain       valid/ready
// pix_out    out  out_red, out_green, out_blue, last     valid/ready
// cfg        in   cfg_index, cfg_data                    cfg_we, no wait
//
// One word per clock while the output does not stall. The word that completes a result passes through these stages:
// window update, pairwise compare in each channel lane, rank select into the output register.
// The line stores are one RAM with registered read, addressed with the next column.
// arst_n clears counters, window and valid flags; line store contents are not cleared.
// A stalled output holds each stage in turn; input stays ready while a stage ahead is empty.
`default_nettype none
`include "rgb_median_filter_3x3_macros.svh"
module rgb_median_filter_3x3 #(
	parameter int MAX_WIDTH    = rmf_pkg::DEF_MAX_WIDTH,
	parameter int CHANNEL_BITS = rmf_pkg::DEF_CHANNEL_BITS
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              cfg_we,
	input wire logic [rmf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input wire logic [rmf_pkg::CFG_DATA_BITS-1:0] cfg_data,
	rmf_pix_in_if.sink                            pix_in,
	rmf_pix_out_if.source                         pix_out
);
	localparam int CB = CHANNEL_BITS;
	localparam int PB = 3 * CB;
	localparam int AB = $clog2(MAX_WIDTH);
	localparam int WB = $clog2(MAX_WIDTH + 1);
	localparam int HB = rmf_pkg::HEIGHT_BITS;
	localparam int N  = rmf_pkg::WIN;

	logic [rmf_pkg::WIDTH_BITS-1:0] cfg_w_q;
	logic [HB-1:0]                  cfg_h_q;
	logic [15:0]                    w_raw;
	logic [WB-1:0]                  w_eff;
	logic [HB-1:0]                  h_eff;

	logic [AB-1:0] in_col_q, col_d, c;
	logic [HB-1:0] in_row_q, row_d;
	logic [AB-1:0] out_col_q;
	logic [HB-1:0] out_row_q;

	logic [PB-1:0]   win_q [3][3];
	logic [PB-1:0]   new_win [3][3];
	logic [2*PB-1:0] ram_rdata;
	logic [PB-1:0]   pix, lower;

	logic cfg_hit, acc, act, row_live, wrap, emit, last, restart;
	logic [WB-1:0] c_inc;
	logic [2:0] col_ok, row_ok;
	logic [N-1:0] mask;

	logic          v_s1, last_s1;
	logic [N-1:0]  mask_s1;
	logic [PB-1:0] win_s1 [N];
	logic          v_s2, last_s2;
	logic          out_v_s3, last_s3;
	logic [CB-1:0] red_s3, green_s3, blue_s3;
	logic          ready2, ready3;

	logic [2:0][CB-1:0] med;

	function automatic logic wrap_out(input logic [AB-1:0] col, input logic [WB-1:0] w);
		return (WB'(col) + WB'(1)) >= w;
	endfunction

	// effective image size
	always_comb begin
		w_raw = 16'(cfg_w_q);
		if (w_raw < 16'd2) begin
			w_eff = WB'(2);
		end else if (w_raw > 16'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(w_raw);
		end
		h_eff = (cfg_h_q < HB'(2)) ? HB'(2) : cfg_h_q;
	end

	assign cfg_hit = cfg_we && ((cfg_index == rmf_pkg::REG_WIDTH) ||
		(cfg_index == rmf_pkg::REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= rmf_pkg::RST_WIDTH;
			cfg_h_q <= rmf_pkg::RST_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmf_pkg::REG_WIDTH:  cfg_w_q <= cfg_data[rmf_pkg::WIDTH_BITS-1:0];
				rmf_pkg::REG_HEIGHT: cfg_h_q <= cfg_data[HB-1:0];
				default: ;
			endcase
		end
	end

	// handshake chain
	assign ready3       = !out_v_s3 || pix_out.ready;
	assign ready2       = !v_s2 || ready3;
	assign pix_in.ready = !v_s1 || ready2;

	assign acc      = pix_in.valid && pix_in.ready;
	assign row_live = in_row_q < h_eff;
	// drop a drain while image pixels are still due
	assign act      = acc && !(row_live && pix_in.drain);

	assign c     = (WB'(in_col_q) < w_eff) ? in_col_q : '0;
	assign c_inc = WB'(c) + WB'(1);
	assign wrap  = c_inc >= w_eff;
	assign emit  = (in_row_q >= HB'(2)) || ((in_row_q == HB'(1)) && (c != '0));
	assign last  = (out_row_q >= h_eff - HB'(1)) && (WB'(out_col_q) >= w_eff - WB'(1));
	assign restart = cfg_hit || (act && emit && last);

	assign pix   = {pix_in.in_blue, pix_in.in_green, pix_in.in_red};
	assign lower = row_live ? pix : '0;

	always_comb begin
		col_d = in_col_q;
		row_d = in_row_q;
		if (restart) begin
			col_d = '0;
			row_d = '0;
		end else if (act) begin
			if (wrap) begin
				col_d = '0;
				if (row_live) begin
					row_d = in_row_q + HB'(1);
				end
			end else begin
				col_d = AB'(c_inc);
			end
		end
	end

	// line stores: upper half middle row, lower half upper row
	rmf_ram #(.WIDTH(2 * PB), .DEPTH(MAX_WIDTH)) u_lines (
		.clk   (clk),
		.we    (act && row_live),
		.waddr (c),
		.wdata ({pix, ram_rdata[2*PB-1:PB]}),
		.raddr (col_d),
		.rdata (ram_rdata)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			new_win[0][k] = win_q[1][k];
			new_win[1][k] = win_q[2][k];
		end
		new_win[2][0] = ram_rdata[PB-1:0];
		new_win[2][1] = ram_rdata[2*PB-1:PB];
		new_win[2][2] = lower;
	end

	// neighbours inside the image
	always_comb begin
		col_ok[0] = out_col_q != '0;
		col_ok[1] = 1'b1;
		col_ok[2] = (WB'(out_col_q) + WB'(1)) < w_eff;
		row_ok[0] = out_row_q != '0;
		row_ok[1] = 1'b1;
		row_ok[2] = ({1'b0, out_row_q} + (HB+1)'(1)) < {1'b0, h_eff};
		for (int dc = 0; dc < 3; dc++) begin
			for (int dr = 0; dr < 3; dr++) begin
				mask[dc*3+dr] = col_ok[dc] && row_ok[dr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					win_q[i][k] <= '0;
				end
			end
		end else begin
			in_col_q <= col_d;
			in_row_q <= row_d;
			if (restart) begin
				out_col_q <= '0;
				out_row_q <= '0;
				for (int i = 0; i < 3; i++) begin
					for (int k = 0; k < 3; k++) begin
						win_q[i][k] <= '0;
					end
				end
			end else if (act) begin
				win_q <= new_win;
				if (emit) begin
					if (wrap_out(out_col_q, w_eff)) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HB'(1);
					end else begin
						out_col_q <= out_col_q + AB'(1);
					end
				end
			end
		end
	end

	// window snapshot stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			v_s1 <= act && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (act && emit) begin
			last_s1 <= last;
			mask_s1 <= mask;
			for (int dc = 0; dc < 3; dc++) begin
				for (int dr = 0; dr < 3; dr++) begin
					win_s1[dc*3+dr] <= new_win[dc][dr];
				end
			end
		end
	end

	// one lane per color channel
	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		logic [N-1:0][CB-1:0] lane_vals;
		rmf_pkg::lane_ctl_t   lane_ctl;

		always_comb begin
			for (int k = 0; k < N; k++) begin
				lane_vals[k] = win_s1[k][ch*CB +: CB];
			end
			lane_ctl.load = ready2;
			lane_ctl.mask = mask_s1;
		end

		rmf_lane #(.CHANNEL_BITS(CB)) u_lane (
			.clk    (clk),
			.ctl    (lane_ctl),
			.vals   (lane_vals),
			.median (med[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2     <= 1'b0;
			out_v_s3 <= 1'b0;
		end else begin
			if (ready2) begin
				v_s2 <= v_s1;
			end
			if (ready3) begin
				out_v_s3 <= v_s2;
			end
		end
	end

	// merge lanes into the output word
	always_ff @(posedge clk) begin
		if (ready2) begin
			last_s2 <= last_s1;
		end
		if (ready3 && v_s2) begin
			red_s3   <= med[0];
			green_s3 <= med[1];
			blue_s3  <= med[2];
			last_s3  <= last_s2;
		end
	end

	assign pix_out.valid      = out_v_s3;
	assign pix_out.out_red    = red_s3;
	assign pix_out.out_green  = green_s3;
	assign pix_out.out_blue   = blue_s3;
	assign pix_out.last_pixel = last_s3;

	`RMF_ASSERT_NOW(a_row_bound, clk, arst_n, 1'b1, in_row_q <= h_eff)
	`RMF_ASSERT_NOW(a_mask_count, clk, arst_n, v_s1,
		($countones(mask_s1) == 9) || ($countones(mask_s1) == 6) || ($countones(mask_s1) == 4))
	`RMF_ASSERT_NEXT(a_end_restart, clk, arst_n, act && emit && last,
		(in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
	`RMF_ASSERT_NEXT(a_s1_hold, clk, arst_n, v_s1 && !ready2, v_s1 && $stable(last_s1))
endmodule
`default_nettype wire
